// ===== rtl/sitda_pkg.sv =====
// shared constants and types for the signed integer to decimal text block
`timescale 1ns / 1ps
`default_nettype none
package sitda_pkg;

  localparam int unsigned NUM_BITS   = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CNT_W      = $clog2(NUM_BITS);
  localparam int unsigned POS_W      = $clog2(NUM_DIGITS);
  localparam int unsigned CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] MINUS_CODE = 6'd45;
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;

  // status from the conversion unit to the sequencer
  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } dab_stat_t;

endpackage
`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// top level: signed 32-bit integer to decimal ascii character stream
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy is low; in_value is a 32-bit
// two's complement integer. The block answers with its decimal text, one ascii
// character per cycle on out_char_out, strobed by out_valid, most significant
// character first, with out_last_char set on the final one. Negative numbers
// get a leading minus sign (the most negative value prints exactly), zero
// prints as a single zero and there are no leading zeros. Busy stays high
// through the conversion in the shift-and-add-3 converter (one input bit per
// cycle), the step that picks the first significant digit and the production
// of every character. Characters leave back to back and the receiver cannot
// stall them; the last character is on the ports in the same cycle that busy
// drops, while a new request may already be taken.
module signed_int_to_decimal_ascii (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic signed [sitda_pkg::NUM_BITS-1:0] in_value,
  output      logic                                out_valid,
  output      logic [sitda_pkg::CHAR_W-1:0]        out_char_out,
  output      logic                                out_last_char
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_SIGN  = 4'b0100,
    ST_DIGIT = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic                           neg_r, neg_nxt;
  logic [sitda_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [sitda_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           accept;
  logic [sitda_pkg::NUM_BITS-1:0] mag;
  logic [sitda_pkg::POS_W-1:0]    top_pos;
  logic [3:0]                     cur_digit;
  sitda_pkg::dab_stat_t           dab;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // magnitude in 32-bit unsigned, so the most negative value wraps onto itself
  assign mag = in_value[sitda_pkg::NUM_BITS-1] ? (~in_value + 1'b1) : in_value;

  sitda_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .mag   (mag),
    .stat  (dab)
  );

  // highest nonzero digit; zero leaves position 0 so one digit is printed
  always_comb begin
    top_pos = '0;
    for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
      if (dab.bcd[i*4 +: 4] != 4'd0) begin
        top_pos = sitda_pkg::POS_W'(i);
      end
    end
  end

  // digit at the current print position
  always_comb begin
    cur_digit = 4'd0;
    for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
      if (pos_r == sitda_pkg::POS_W'(i)) begin
        cur_digit = dab.bcd[i*4 +: 4];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt   = in_value[sitda_pkg::NUM_BITS-1];
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        // converter finished: locate the first digit to print
        if (dab.done) begin
          pos_nxt   = top_pos;
          state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sitda_pkg::MINUS_CODE;
        state_nxt     = ST_DIGIT;
      end
      ST_DIGIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sitda_pkg::DIGIT_BASE + {2'b00, cur_digit};
        if (pos_r == '0) begin
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          pos_nxt = pos_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_last_char = out_last_r;

  // a taken request makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after request");

  // the final character leaves with the sequencer already idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_char) |-> !busy)
    else $error("busy still high on final character");

  // converter only reports completion while the sequencer waits for it
  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    dab.done |-> (state_r == ST_CONV))
    else $error("conversion done outside conversion phase");

  // only a minus sign or a decimal digit is ever emitted
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_out == sitda_pkg::MINUS_CODE) ||
                   ((out_char_out >= sitda_pkg::DIGIT_BASE) &&
                    (out_char_out <= sitda_pkg::DIGIT_BASE + 6'd9))))
    else $error("illegal character code");

  // a minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_char_out == sitda_pkg::MINUS_CODE)) |-> !out_last_char)
    else $error("minus sign flagged as last");

endmodule
`default_nettype wire

// ===== rtl/sitda_dabble.sv =====
// iterative binary to bcd converter, one shift-and-adjust step per cycle
`timescale 1ns / 1ps
`default_nettype none
module sitda_dabble (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic [sitda_pkg::NUM_BITS-1:0] mag,
  output sitda_pkg::dab_stat_t               stat
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [sitda_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [sitda_pkg::NUM_BITS-1:0]  bin_r, bin_nxt;
  logic [sitda_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [sitda_pkg::BCD_W-1:0]     adj;

  // add-3 on every digit of five or more, then shift one bit in
  always_comb begin
    for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      bin_nxt  = mag;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt = {adj[sitda_pkg::BCD_W-2:0], bin_r[sitda_pkg::NUM_BITS-1]};
      bin_nxt = {bin_r[sitda_pkg::NUM_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sitda_pkg::CNT_W'(sitda_pkg::NUM_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.done = done_r;
  assign stat.bcd  = bcd_r;

endmodule
`default_nettype wire
